// ===== hw/rtl/fdc_pkg.sv =====
// Package for the fan duty curve block: field widths, payload and register types,
// the controller/datapath command and status structs, and reset values.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

  localparam int unsigned PWM_TOP_DEF = 320;

  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned DEG_W    = 7;
  localparam int unsigned BAND_W   = 4;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned CMP_W    = 9;
  localparam int unsigned TENTHS_W = 11;   // tenths of a degree, up to 1270
  localparam int unsigned NUM_W    = 17;   // tenths difference times 100
  localparam int unsigned QUO_W    = 7;    // interpolated duty, below 128

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // x/100 as (x/4)/25, with 1/25 taken as 20972 / 2^19
  localparam int unsigned RECIP_MUL   = 20972;
  localparam int unsigned RECIP_W     = 15;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [DEG_W-1:0]  START_RST = 7'd30;
  localparam logic [DEG_W-1:0]  END_RST   = 7'd50;
  localparam logic [BAND_W-1:0] BAND_RST  = 4'd3;

  localparam logic [DUTY_W-1:0] DUTY_ZERO = 7'd0;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_sixteenths;
    logic                     sample_valid;
    logic                     in_startup;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_percent;
    logic [CMP_W-1:0]  compare_value;
  } out_t;

  typedef struct packed {
    logic [DEG_W-1:0]  start_temp;
    logic [DEG_W-1:0]  end_temp;
    logic [BAND_W-1:0] hysteresis_band;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_BAND  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_INTERP = 2'd0,
    CLS_ZERO   = 2'd1,
    CLS_FULL   = 2'd2,
    CLS_FORCE  = 2'd3
  } cls_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic scale;
    logic div_step;
    logic hyst;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fdc_regs.sv =====
// Configuration registers behind the APB-style port: start, end and band.
// Depends on fdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fdc_pkg::APB_AW-1:0]    paddr,
  input  wire logic [fdc_pkg::APB_DW-1:0]    pwdata,
  output logic      [fdc_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  output fdc_pkg::cfg_t                      cfg
);
  import fdc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_START: cfg_nxt.start_temp      = pwdata[DEG_W-1:0];
        REG_END:   cfg_nxt.end_temp        = pwdata[DEG_W-1:0];
        REG_BAND:  cfg_nxt.hysteresis_band = pwdata[BAND_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START: prdata = APB_DW'(cfg_r.start_temp);
      REG_END:   prdata = APB_DW'(cfg_r.end_temp);
      REG_BAND:  prdata = APB_DW'(cfg_r.hysteresis_band);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_temp      <= START_RST;
      cfg_r.end_temp        <= END_RST;
      cfg_r.hysteresis_band <= BAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fdc_ctrl.sv =====
// Sequencing state machine: accept, classify, scale, divide, hysteresis, PWM scale, emit.
// Depends on fdc_pkg; drives the command struct into fdc_dp.
`timescale 1ns / 1ps
`default_nettype none

module fdc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  fdc_pkg::sts_t      sts,
  output fdc_pkg::cmd_t      cmd
);
  import fdc_pkg::*;

  localparam int unsigned       CNT_W    = $clog2(QUO_W);
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(QUO_W - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_SCALE = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_HYST  = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_HYST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_HYST: begin
        cmd.hyst  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the item
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DIV) |-> (cnt_r == '0))
    else $error("divider step count not parked outside the divide phase");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/fdc_dp.sv =====
// Datapath: sample registers, curve classification, restoring divider,
// hysteresis state, PWM compare scaling and the output register. Depends on fdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdc_dp #(
  parameter int unsigned PWM_TOP = fdc_pkg::PWM_TOP_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  fdc_pkg::in_t       in_data,
  input  fdc_pkg::cfg_t      cfg,
  input  fdc_pkg::cmd_t      cmd,
  output fdc_pkg::sts_t      sts,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fdc_pkg::out_t      out_data
);
  import fdc_pkg::*;

  localparam int unsigned PROD_W = $clog2(100 * PWM_TOP + 1);
  localparam int unsigned Y_W    = PROD_W - 2;
  localparam int unsigned SC_W   = (Y_W + RECIP_W > RECIP_SHIFT + CMP_W) ?
                                   Y_W + RECIP_W : RECIP_SHIFT + CMP_W;

  logic signed [TEMP_W-1:0] t_r, t_nxt;
  logic                     force_r, force_nxt;
  cls_t                     cls_r, cls_nxt;
  logic [TENTHS_W-1:0]      dif_r, dif_nxt;
  logic [TENTHS_W-1:0]      den_r, den_nxt;
  logic [NUM_W-1:0]         rem_r, rem_nxt;
  logic [NUM_W-1:0]         dsr_r, dsr_nxt;
  logic [QUO_W-1:0]         quo_r, quo_nxt;
  logic [DUTY_W-1:0]        duty_r, duty_nxt;
  logic [DUTY_W-1:0]        held_r, held_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_data_r, out_data_nxt;

  logic signed [TEMP_W-1:0] lo_s, hi_s;
  logic [14:0]              t_x10;
  logic [TENTHS_W-1:0]      t10, start10, end10;
  logic                     ge;
  logic [DUTY_W-1:0]        cand, diff;
  logic [Y_W-1:0]           y;
  logic [SC_W-1:0]          scaled;

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // curve bounds in sixteenths, and the sample in tenths (sample is positive when used)
  assign lo_s    = $signed({1'b0, cfg.start_temp, 4'b0000});
  assign hi_s    = $signed({1'b0, cfg.end_temp, 4'b0000});
  assign t_x10   = 15'({t_r[10:0], 3'b000}) + 15'({t_r[10:0], 1'b0});
  assign t10     = t_x10[14:4];
  assign start10 = TENTHS_W'({cfg.start_temp, 3'b000}) + TENTHS_W'({cfg.start_temp, 1'b0});
  assign end10   = TENTHS_W'({cfg.end_temp, 3'b000}) + TENTHS_W'({cfg.end_temp, 1'b0});

  assign ge = (rem_r >= dsr_r);

  assign diff = (cand >= held_r) ? (cand - held_r) : (held_r - cand);

  assign y      = prod_r[PROD_W-1:2];
  assign scaled = SC_W'(y) * SC_W'(RECIP_MUL);

  always_comb begin
    unique case (cls_r)
      CLS_ZERO:   cand = DUTY_ZERO;
      CLS_FULL:   cand = DUTY_FULL;
      CLS_FORCE:  cand = DUTY_FULL;
      CLS_INTERP: cand = quo_r;
      default:    cand = DUTY_FULL;
    endcase
  end

  always_comb begin
    t_nxt         = t_r;
    force_nxt     = force_r;
    cls_nxt       = cls_r;
    dif_nxt       = dif_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    quo_nxt       = quo_r;
    duty_nxt      = duty_r;
    held_nxt      = held_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    if (cmd.load) begin
      t_nxt     = in_data.temp_sixteenths;
      force_nxt = !in_data.sample_valid || in_data.in_startup;
    end

    if (cmd.prep) begin
      priority if (force_r)      cls_nxt = CLS_FORCE;
      else if (t_r <= lo_s)      cls_nxt = CLS_ZERO;
      else if (t_r >= hi_s)      cls_nxt = CLS_FULL;
      else                       cls_nxt = CLS_INTERP;
      dif_nxt = t10 - start10;
      den_nxt = end10 - start10;
    end

    if (cmd.scale) begin
      rem_nxt = NUM_W'({dif_r, 6'b0}) + NUM_W'({dif_r, 5'b0}) + NUM_W'({dif_r, 2'b0});
      dsr_nxt = NUM_W'({den_r, 6'b0});
      quo_nxt = '0;
    end

    // one quotient bit per step, divisor walks right
    if (cmd.div_step) begin
      if (ge) begin
        rem_nxt = rem_r - dsr_r;
      end
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      dsr_nxt = dsr_r >> 1;
    end

    if (cmd.hyst) begin
      priority if (cls_r == CLS_FORCE) begin
        duty_nxt = DUTY_FULL;
      end else if (cand == DUTY_ZERO || cand == DUTY_FULL) begin
        duty_nxt = cand;
      end else if (diff < DUTY_W'(cfg.hysteresis_band)) begin
        duty_nxt = held_r;
      end else begin
        duty_nxt = cand;
        held_nxt = cand;
      end
    end

    if (cmd.mul) begin
      prod_nxt = PROD_W'(duty_r) * PROD_W'(PWM_TOP);
    end

    if (cmd.emit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.duty_percent  = duty_r;
      out_data_nxt.compare_value = scaled[RECIP_SHIFT +: CMP_W];
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    force_r    <= force_nxt;
    cls_r      <= cls_nxt;
    dif_r      <= dif_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    dsr_r      <= dsr_nxt;
    quo_r      <= quo_nxt;
    duty_r     <= duty_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= 7'd99)
    else $error("held duty outside the interpolated range");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hyst && cls_r == CLS_INTERP) |-> (quo_r < DUTY_FULL))
    else $error("interpolated duty out of range after division");

  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (out_valid_r && out_data_r.duty_percent <= DUTY_FULL))
    else $error("emitted item missing or duty above full scale");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/fan_duty_curve_with_hysteresis.sv =====
// Fan duty curve block, top level: joins registers, controller and datapath.
// Depends on fdc_pkg, fdc_regs, fdc_ctrl and fdc_dp.
//
// Each temperature sample (signed 1/16 degree) gives one item: the fan duty in
// percent and the PWM compare value duty*PWM_TOP/100. An invalid sample or the
// start-up flag forces full duty without touching the held duty. Otherwise the
// duty is 0 at or below start_temp, 100 at or above end_temp, and a truncated
// linear interpolation on tenths of a degree in between, filtered by a
// hysteresis band that keeps the held duty on small changes. An item passes
// through the seven-step restoring divider on its way to the output register;
// the next sample is taken the cycle after the result is registered, while that
// result may still wait on out_stall, so no new sample is taken while an item is
// still on its way to the output register. Configuration registers: start_temp
// at 0x0, end_temp at 0x4, hysteresis_band at 0x8.
`timescale 1ns / 1ps
`default_nettype none

module fan_duty_curve_with_hysteresis #(
  parameter int unsigned PWM_TOP = fdc_pkg::PWM_TOP_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  fdc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output fdc_pkg::out_t                    out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fdc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [fdc_pkg::APB_DW-1:0]  pwdata,
  output logic      [fdc_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  import fdc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  fdc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fdc_dp #(
    .PWM_TOP (PWM_TOP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/tb_fan_duty_curve_with_hysteresis.sv =====
// Self-checking bench for fan_duty_curve_with_hysteresis: a directed table, then random
// temperature walks across several curve settings written over the APB-style port.
// Depends on fdc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_fan_duty_curve_with_hysteresis;
  import fdc_pkg::*;

  localparam int unsigned CMP_TOP = PWM_TOP_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS = 23;
  localparam int FIXED_CURVES = 9;
  localparam int CURVES = 12;
  localparam int CURVE_ITEMS = 67;
  localparam int TEMP_MIN = -880;
  localparam int TEMP_MAX = 2000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_t;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cfg_t              curve_cfg;
  logic [DUTY_W-1:0] duty_held;
  out_t              pending_duty[$];
  int                errors = 0;
  int                cycle_count = 0;
  int                burst_left = 0;
  bit                gaps_on = 1'b1;
  dir_row_t          directed_rows [DIR_ROWS];
  cfg_t              fixed_curves [FIXED_CURVES];

  always #5 clk = ~clk;

  fan_duty_curve_with_hysteresis #(
    .PWM_TOP(CMP_TOP)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Duty and compare value for one sample; updates the held duty as the block would.
  function automatic out_t fan_duty_for(in_t s);
    int t, lo, hi, t10, num, den, d, diff;
    out_t r;
    t = $signed(s.temp_sixteenths);
    if (!s.sample_valid || s.in_startup) begin
      d = 100;
    end else begin
      lo = int'(curve_cfg.start_temp) * 16;
      hi = int'(curve_cfg.end_temp) * 16;
      if (t <= lo) begin
        d = 0;
      end else if (t >= hi) begin
        d = 100;
      end else begin
        // t is positive here, so the division truncates like a shift
        t10 = (t * 10) / 16;
        num = (t10 - int'(curve_cfg.start_temp) * 10) * 100;
        den = (int'(curve_cfg.end_temp) - int'(curve_cfg.start_temp)) * 10;
        d = num / den;
      end
      if (d != 0 && d != 100) begin
        diff = d - int'(duty_held);
        if (diff < 0) diff = -diff;
        if (diff < int'(curve_cfg.hysteresis_band)) d = int'(duty_held);
        else duty_held = DUTY_W'(d);
      end
    end
    r.duty_percent = DUTY_W'(d);
    r.compare_value = CMP_W'(d * int'(CMP_TOP) / 100);
    return r;
  endfunction

  function automatic dir_row_t row(int t, bit v, bit st, bit typed, int d, int c);
    dir_row_t r;
    r.item.temp_sixteenths = TEMP_W'(t);
    r.item.sample_valid = v;
    r.item.in_startup = st;
    r.typed = typed;
    r.want.duty_percent = DUTY_W'(d);
    r.want.compare_value = CMP_W'(c);
    return r;
  endfunction

  // Mostly small steps around the curve so the hysteresis sees real traffic.
  function automatic int pick_temp(int last);
    int lo, hi, r, t;
    lo = ((curve_cfg.start_temp < curve_cfg.end_temp) ?
          int'(curve_cfg.start_temp) : int'(curve_cfg.end_temp)) * 16 - 32;
    hi = ((curve_cfg.start_temp > curve_cfg.end_temp) ?
          int'(curve_cfg.start_temp) : int'(curve_cfg.end_temp)) * 16 + 32;
    if (lo < TEMP_MIN) lo = TEMP_MIN;
    if (hi > TEMP_MAX) hi = TEMP_MAX;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      t = last + int'($urandom_range(0, 48)) - 24;
      if (t < lo || t > hi) t = lo + int'($urandom_range(0, hi - lo));
    end else if (r < 80) begin
      t = lo + int'($urandom_range(0, hi - lo));
    end else if (r < 95) begin
      t = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN));
    end else begin
      t = int'($urandom_range(0, 4095)) - 2048;
    end
    return t;
  endfunction

  task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input reg_idx_t idx, output logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    data = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input reg_idx_t idx, input int value);
    logic [APB_DW-1:0] back;
    apb_read(idx, back);
    if (back !== APB_DW'(value)) begin
      $display("%0t: register %s read back: expected %0d, actual %0d",
               $time, idx.name(), value, back);
      errors++;
    end
  endtask

  // Write with random noise above the field, then read back the field alone.
  task automatic set_register(input reg_idx_t idx, input int value);
    logic [APB_DW-1:0] data;
    data = APB_DW'(value);
    if ($urandom_range(0, 1) == 1) data = data | ($urandom() << 7);
    apb_write(idx, data);
    check_register(idx, value);
    case (idx)
      REG_START: curve_cfg.start_temp = DEG_W'(value);
      REG_END:   curve_cfg.end_temp = DEG_W'(value);
      default:   curve_cfg.hysteresis_band = BAND_W'(value);
    endcase
  endtask

  task automatic send_item(input in_t item, input bit typed, input out_t want);
    int gap;
    out_t guess;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    guess = fan_duty_for(item);
    pending_duty.push_back(typed ? want : guess);
  endtask

  // Drop valid and let every outstanding item come back.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : out_stall_pattern
    stall_mode_t mode;
    int span, k;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 150);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
          default:     out_stall <= ((k % 24) < 14);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_duty.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, actual duty %0d cmp %0d",
                 $time, out_data.duty_percent, out_data.compare_value);
        errors++;
      end else begin
        want = pending_duty.pop_front();
        if (out_data.duty_percent !== want.duty_percent) begin
          $display("%0t: duty_percent: expected %0d, actual %0d",
                   $time, want.duty_percent, out_data.duty_percent);
          errors++;
        end
        if (out_data.compare_value !== want.compare_value) begin
          $display("%0t: compare_value: expected %0d, actual %0d",
                   $time, want.compare_value, out_data.compare_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d items pending", $time, pending_duty.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    in_t item;
    cfg_t c;
    int p, i, last_temp;

    curve_cfg.start_temp = START_RST;
    curve_cfg.end_temp = END_RST;
    curve_cfg.hysteresis_band = BAND_RST;
    duty_held = '0;

    // Reset curve 30..50 degrees, band 3, nothing held yet.
    directed_rows = '{
      row(-2048, 1, 0, 1, 0, 0),
      row(TEMP_MIN, 1, 0, 1, 0, 0),
      row(0, 1, 0, 1, 0, 0),
      row(480, 1, 0, 1, 0, 0),        // exactly the start temperature
      row(481, 1, 0, 1, 0, 0),        // just above start, interpolates to zero
      row(2047, 1, 0, 1, 100, 320),
      row(TEMP_MAX, 1, 0, 1, 100, 320),
      row(800, 1, 0, 1, 100, 320),    // exactly the end temperature
      row(640, 0, 0, 1, 100, 320),    // invalid sample
      row(640, 1, 1, 1, 100, 320),    // start-up
      row(TEMP_MIN, 0, 1, 1, 100, 320),
      row(-1, 1, 0, 1, 0, 0),
      row(640, 1, 0, 0, 0, 0),
      row(648, 1, 0, 0, 0, 0),        // change under the band: hold
      row(656, 1, 0, 0, 0, 0),
      row(652, 1, 0, 0, 0, 0),
      row(799, 1, 0, 0, 0, 0),
      row(700, 0, 0, 1, 100, 320),    // forced full must not disturb the held duty
      row(797, 1, 0, 0, 0, 0),
      row(482, 1, 0, 0, 0, 0),
      row(490, 1, 0, 0, 0, 0),
      row(1365, 1, 0, 1, 100, 320),
      row(-1366, 1, 0, 1, 0, 0)
    };

    fixed_curves = '{
      {7'd30, 7'd50, 4'd3},
      {7'd0, 7'd127, 4'd0},
      {7'd127, 7'd0, 4'd15},
      {7'd125, 7'd0, 4'd10},
      {7'd0, 7'd0, 4'd0},
      {7'd20, 7'd21, 4'd1},
      {7'd45, 7'd45, 4'd10},
      {7'd0, 7'd125, 4'd7},
      {7'd60, 7'd62, 4'd15}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_register(REG_START, START_RST);
    check_register(REG_END, END_RST);
    check_register(REG_BAND, BAND_RST);

    for (i = 0; i < DIR_ROWS; i++) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    drain;

    for (p = 0; p < CURVES; p++) begin
      if (p < FIXED_CURVES) begin
        c = fixed_curves[p];
      end else begin
        c.start_temp = DEG_W'($urandom_range(0, 125));
        c.end_temp = DEG_W'($urandom_range(0, 125));
        // keep most random curves rising
        if ($urandom_range(0, 3) != 0 && c.start_temp > c.end_temp) begin
          c.end_temp = c.start_temp ^ c.end_temp;
          c.start_temp = c.start_temp ^ c.end_temp;
          c.end_temp = c.start_temp ^ c.end_temp;
        end
        c.hysteresis_band = BAND_W'($urandom_range(0, 10));
      end
      set_register(REG_START, c.start_temp);
      set_register(REG_END, c.end_temp);
      set_register(REG_BAND, c.hysteresis_band);
      gaps_on = (p % 3 != 1);
      last_temp = int'(c.start_temp) * 16;
      for (i = 0; i < CURVE_ITEMS; i++) begin
        last_temp = pick_temp(last_temp);
        item.temp_sixteenths = TEMP_W'(last_temp);
        item.sample_valid = ($urandom_range(0, 19) != 0);
        item.in_startup = ($urandom_range(0, 24) == 0);
        send_item(item, 1'b0, '0);
      end
      drain;
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fdc_pkg.sv
hw/rtl/fdc_regs.sv
hw/rtl/fdc_ctrl.sv
hw/rtl/fdc_dp.sv
hw/rtl/fan_duty_curve_with_hysteresis.sv
bench/tb_fan_duty_curve_with_hysteresis.sv
